// File: rtl/sfce_pkg.sv
// shared types and constants for the spi nor flash command engine
package sfce_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_STAT, PH_ID, PH_SR3, PH_EN4B, PH_WREN, PH_WRSR3, PH_ERASE,
    PH_CHIP, PH_WRDI, PH_RHDR, PH_RDATA, PH_PHDR, PH_PWANT, PH_PDATA,
    PH_POLL_OP, PH_POLL_DATA, PH_POLL_DLY
  } phase_t;

  typedef enum logic [1:0] {
    WT_EN4B, WT_WREN, WT_CMD
  } wtag_t;

  // input item kinds
  localparam logic [1:0] IK_CMD   = 2'd0;
  localparam logic [1:0] IK_WDATA = 2'd1;
  localparam logic [1:0] IK_RX    = 2'd2;
  localparam logic [1:0] IK_DELAY = 2'd3;

  // result kinds
  localparam logic [2:0] OK_SPI   = 3'd0;
  localparam logic [2:0] OK_RDATA = 3'd1;
  localparam logic [2:0] OK_WANT  = 3'd2;
  localparam logic [2:0] OK_DELAY = 3'd3;
  localparam logic [2:0] OK_DONE  = 3'd4;

  // commands
  localparam logic [2:0] OP_STATUS = 3'd0;
  localparam logic [2:0] OP_ID     = 3'd1;
  localparam logic [2:0] OP_EN4B   = 3'd2;
  localparam logic [2:0] OP_SECTOR = 3'd3;
  localparam logic [2:0] OP_BLOCK  = 3'd4;
  localparam logic [2:0] OP_CHIP   = 3'd5;
  localparam logic [2:0] OP_READ   = 3'd6;
  localparam logic [2:0] OP_PROG   = 3'd7;

  // flash opcodes
  localparam logic [7:0] FC_RDSR1  = 8'h05;
  localparam logic [7:0] FC_RDSR2  = 8'h35;
  localparam logic [7:0] FC_RDSR3  = 8'h15;
  localparam logic [7:0] FC_WRSR3  = 8'h11;
  localparam logic [7:0] FC_RDID   = 8'h9F;
  localparam logic [7:0] FC_EN4B   = 8'hB7;
  localparam logic [7:0] FC_WREN   = 8'h06;
  localparam logic [7:0] FC_WRDI   = 8'h04;
  localparam logic [7:0] FC_CE     = 8'hC7;
  localparam logic [7:0] FC_SE3    = 8'h20;
  localparam logic [7:0] FC_SE4    = 8'h21;
  localparam logic [7:0] FC_BE3    = 8'hD8;
  localparam logic [7:0] FC_BE4    = 8'hDC;
  localparam logic [7:0] FC_FR3    = 8'h0B;
  localparam logic [7:0] FC_FR4    = 8'h0C;
  localparam logic [7:0] FC_PP3    = 8'h02;
  localparam logic [7:0] FC_PP4    = 8'h12;
  localparam logic [7:0] FC_DUMMY  = 8'hFF;
  localparam logic [7:0] SR3_ADP   = 8'h02;

  localparam logic [15:0] POLL_RESET = 16'd50000;

  // register byte addresses
  localparam logic [2:0] RA_FOUR  = 3'd0;
  localparam logic [2:0] RA_LIMIT = 3'd4;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx;
    logic        fe;
    logic [7:0]  rb;
    logic        last;
    logic        st;
    logic [23:0] rv;
  } res_t;

  // results of one item for the result queue
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } wr_t;

endpackage

// File: rtl/sfce_if.sv
// item and result channel interfaces
interface sfce_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  op;
  logic [31:0] address;
  logic [15:0] length;
  logic [7:0]  data_byte;
  modport source (output valid, kind, op, address, length, data_byte, input ready);
  modport sink (input valid, kind, op, address, length, data_byte, output ready);
endinterface

interface sfce_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic [7:0]  tx_byte;
  logic        frame_end;
  logic [7:0]  read_byte;
  logic        last;
  logic        status;
  logic [23:0] reply_value;
  modport source (output valid, out_kind, tx_byte, frame_end, read_byte, last, status,
                  reply_value, input ready);
  modport sink (input valid, out_kind, tx_byte, frame_end, read_byte, last, status,
                reply_value, output ready);
endinterface

// File: rtl/spi_nor_flash_command_engine_core.sv
// spi nor flash command engine top level
// results of an accepted item enter the result queue in the following cycle
// throughput: one item per cycle while the queue holds at most two results;
//   an item yields at most two results, and the queue drains one per cycle while out_ch.ready is high
// reset: synchronous active-low rst_n idles the sequencer, empties the queue,
//   and loads four_byte_addr 0 and poll_limit 50000
module spi_nor_flash_command_engine_core #(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  sfce_in_if.sink     in_ch,
  sfce_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic           four_byte;
  logic [15:0]    poll_limit;
  logic           go;
  logic           room;
  logic           idle;
  sfce_pkg::wr_t  wr;
  sfce_pkg::res_t head;

  // apb registers, no wait states
  assign cfg_pready = 1'b1;

  sfce_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .four_byte  (four_byte),
    .poll_limit (poll_limit)
  );

  // an item transfer happens whenever the queue can take its results
  assign in_ch.ready = room;
  assign go          = in_ch.valid & room;

  sfce_step #(.PAGE_BYTES(PAGE_BYTES)) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .kind      (in_ch.kind),
    .op        (in_ch.op),
    .address   (in_ch.address),
    .length    (in_ch.length),
    .data_byte (in_ch.data_byte),
    .cfg_four  (four_byte),
    .cfg_limit (poll_limit),
    .wr        (wr),
    .idle      (idle)
  );

  // result queue decouples the sequencer from output stalls
  sfce_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .room  (room),
    .valid (out_ch.valid),
    .pop   (out_ch.ready),
    .head  (head)
  );

  assign out_ch.out_kind    = head.kind;
  assign out_ch.tx_byte     = head.tx;
  assign out_ch.frame_end   = head.fe;
  assign out_ch.read_byte   = head.rb;
  assign out_ch.last        = head.last;
  assign out_ch.status      = head.st;
  assign out_ch.reply_value = head.rv;

  // spi and done fields stay zero outside their result kind
  a_spi_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_kind != sfce_pkg::OK_SPI |->
      out_ch.tx_byte == 8'd0 && !out_ch.frame_end)
    else $error("spi fields set on a non-spi result");
  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_kind != sfce_pkg::OK_DONE |->
      !out_ch.status && out_ch.reply_value == 24'd0)
    else $error("done fields set on another result");
  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    go && in_ch.kind == sfce_pkg::IK_CMD && idle |=> out_ch.valid)
    else $error("command gave no result");

endmodule

// File: rtl/sfce_cfg.sv
// apb configuration registers
module sfce_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        four_byte,
  output logic [15:0] poll_limit
);

  logic        four_r, four_nxt;
  logic [15:0] lim_r, lim_nxt;
  logic        wr_en;

  assign wr_en = psel & penable & pwrite;

  always_comb begin
    four_nxt = four_r;
    lim_nxt  = lim_r;
    if (wr_en) begin
      unique case (paddr[2])
        sfce_pkg::RA_LIMIT[2]: lim_nxt  = pwdata[15:0];
        default:               four_nxt = pwdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_r <= 1'b0;
      lim_r  <= sfce_pkg::POLL_RESET;
    end else begin
      four_r <= four_nxt;
      lim_r  <= lim_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      sfce_pkg::RA_LIMIT[2]: prdata = {16'd0, lim_r};
      default:               prdata = {31'd0, four_r};
    endcase
  end

  assign four_byte  = four_r;
  assign poll_limit = lim_r;

endmodule

// File: rtl/sfce_step.sv
// command sequencer state and per-item result logic
module sfce_step #(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  logic [1:0]     kind,
  input  logic [2:0]     op,
  input  logic [31:0]    address,
  input  logic [15:0]    length,
  input  logic [7:0]     data_byte,
  input  logic           cfg_four,
  input  logic [15:0]    cfg_limit,
  output sfce_pkg::wr_t  wr,
  output logic           idle
);

  // page size must be a power of two
  localparam int unsigned OW = $clog2(PAGE_BYTES);
  localparam int unsigned PW = $clog2(PAGE_BYTES + 1);

  typedef enum logic [2:0] {ACT_NONE, ACT_SEND, ACT_FIN, ACT_POLL, ACT_EMIT} act_t;

  sfce_pkg::phase_t ph_r, ph_nxt;
  sfce_pkg::wtag_t  tag_r, tag_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [15:0] bl_r, bl_nxt;
  logic [PW-1:0] pl_r, pl_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [23:0] rs_r, rs_nxt;
  logic [7:0]  sr3_r, sr3_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        a4_r, a4_nxt;
  logic        to_r, to_nxt;

  act_t            act;
  sfce_pkg::res_t  emit_r, pre_r;
  logic            pre_v;

  function automatic logic [2:0] frame_len(sfce_pkg::phase_t p, logic a4);
    logic [2:0] al;
    begin
      al = a4 ? 3'd4 : 3'd3;
      case (p)
        sfce_pkg::PH_STAT:  frame_len = 3'd6;
        sfce_pkg::PH_ID:    frame_len = 3'd4;
        sfce_pkg::PH_SR3,
        sfce_pkg::PH_WRSR3: frame_len = 3'd2;
        sfce_pkg::PH_ERASE,
        sfce_pkg::PH_PHDR:  frame_len = 3'(al + 3'd1);
        sfce_pkg::PH_RHDR:  frame_len = 3'(al + 3'd2);
        default:            frame_len = 3'd1;
      endcase
    end
  endfunction

  function automatic sfce_pkg::res_t send_now(sfce_pkg::phase_t p, logic [2:0] s,
      logic a4, logic [31:0] ad, logic bl_nz, logic pl_nz, logic [7:0] sr3,
      logic [2:0] cop);
    sfce_pkg::res_t r;
    logic [2:0] al;
    logic [1:0] sh;
    logic [7:0] oc, ab, b;
    logic       fe;
    begin
      r  = '0;
      al = a4 ? 3'd4 : 3'd3;
      case (cop)
        sfce_pkg::OP_SECTOR: oc = a4 ? sfce_pkg::FC_SE4 : sfce_pkg::FC_SE3;
        sfce_pkg::OP_BLOCK:  oc = a4 ? sfce_pkg::FC_BE4 : sfce_pkg::FC_BE3;
        sfce_pkg::OP_READ:   oc = a4 ? sfce_pkg::FC_FR4 : sfce_pkg::FC_FR3;
        default:             oc = a4 ? sfce_pkg::FC_PP4 : sfce_pkg::FC_PP3;
      endcase
      sh = 2'(al - s);
      case (sh)
        2'd0:    ab = ad[7:0];
        2'd1:    ab = ad[15:8];
        2'd2:    ab = ad[23:16];
        default: ab = ad[31:24];
      endcase
      if (s > al) ab = sfce_pkg::FC_DUMMY;
      case (p)
        sfce_pkg::PH_STAT: begin
          if (s[0]) b = sfce_pkg::FC_DUMMY;
          else if (s[2:1] == 2'd0) b = sfce_pkg::FC_RDSR1;
          else if (s[2:1] == 2'd1) b = sfce_pkg::FC_RDSR2;
          else b = sfce_pkg::FC_RDSR3;
        end
        sfce_pkg::PH_ID:    b = (s == 3'd0) ? sfce_pkg::FC_RDID : sfce_pkg::FC_DUMMY;
        sfce_pkg::PH_SR3:   b = (s == 3'd0) ? sfce_pkg::FC_RDSR3 : sfce_pkg::FC_DUMMY;
        sfce_pkg::PH_EN4B:  b = sfce_pkg::FC_EN4B;
        sfce_pkg::PH_WREN:  b = sfce_pkg::FC_WREN;
        sfce_pkg::PH_WRSR3: b = (s == 3'd0) ? sfce_pkg::FC_WRSR3 : (sr3 | sfce_pkg::SR3_ADP);
        sfce_pkg::PH_CHIP:  b = sfce_pkg::FC_CE;
        sfce_pkg::PH_WRDI:  b = sfce_pkg::FC_WRDI;
        sfce_pkg::PH_ERASE,
        sfce_pkg::PH_PHDR,
        sfce_pkg::PH_RHDR:  b = (s == 3'd0) ? oc : ab;
        default:            b = sfce_pkg::FC_DUMMY;
      endcase
      if (p == sfce_pkg::PH_STAT) fe = s[0];
      else begin
        fe = (3'(s + 3'd1) == frame_len(p, a4));
        if (p == sfce_pkg::PH_RHDR && bl_nz) fe = 1'b0;
        if (p == sfce_pkg::PH_PHDR && pl_nz) fe = 1'b0;
      end
      r.kind = sfce_pkg::OK_SPI;
      r.tx   = b;
      r.fe   = fe;
      send_now = r;
    end
  endfunction

  // next state and the action that the item causes
  always_comb begin
    logic [PW-1:0] n;
    logic [15:0]   lim;
    logic          ok;
    logic [2:0]    st1;
    ph_nxt   = ph_r;
    tag_nxt  = tag_r;
    op_nxt   = op_r;
    addr_nxt = addr_r;
    bl_nxt   = bl_r;
    pl_nxt   = pl_r;
    pc_nxt   = pc_r;
    rs_nxt   = rs_r;
    sr3_nxt  = sr3_r;
    step_nxt = step_r;
    a4_nxt   = a4_r;
    to_nxt   = to_r;
    act      = ACT_NONE;
    emit_r   = '0;
    pre_r    = '0;
    pre_v    = 1'b0;
    n        = PW'(PAGE_BYTES) - PW'(addr_r[OW-1:0]);
    lim      = (cfg_limit == 16'd0) ? 16'd1 : cfg_limit;
    ok       = 1'b0;
    st1      = 3'(step_r + 3'd1);
    if (go) begin
      case (kind)
        sfce_pkg::IK_CMD: begin
          if (ph_r == sfce_pkg::PH_IDLE) begin
            op_nxt   = op;
            addr_nxt = address;
            bl_nxt   = length;
            a4_nxt   = cfg_four;
            to_nxt   = 1'b0;
            rs_nxt   = '0;
            step_nxt = '0;
            act      = ACT_SEND;
            case (op)
              sfce_pkg::OP_STATUS: ph_nxt = sfce_pkg::PH_STAT;
              sfce_pkg::OP_ID:     ph_nxt = sfce_pkg::PH_ID;
              sfce_pkg::OP_EN4B:   ph_nxt = sfce_pkg::PH_SR3;
              sfce_pkg::OP_READ:   ph_nxt = sfce_pkg::PH_RHDR;
              default:             ph_nxt = sfce_pkg::PH_WREN;
            endcase
          end
        end
        sfce_pkg::IK_WDATA: begin
          if (ph_r == sfce_pkg::PH_PWANT) begin
            ph_nxt      = sfce_pkg::PH_PDATA;
            act         = ACT_EMIT;
            emit_r.kind = sfce_pkg::OK_SPI;
            emit_r.tx   = data_byte;
            emit_r.fe   = (pl_r == PW'(1));
          end
        end
        sfce_pkg::IK_DELAY: begin
          if (ph_r == sfce_pkg::PH_POLL_DLY) begin
            ph_nxt      = sfce_pkg::PH_POLL_OP;
            act         = ACT_EMIT;
            emit_r.kind = sfce_pkg::OK_SPI;
            emit_r.tx   = sfce_pkg::FC_RDSR1;
          end
        end
        default: begin
          unique case (ph_r)
            sfce_pkg::PH_IDLE, sfce_pkg::PH_PWANT, sfce_pkg::PH_POLL_DLY: ;
            sfce_pkg::PH_RDATA: begin
              pre_v       = 1'b1;
              pre_r.kind  = sfce_pkg::OK_RDATA;
              pre_r.rb    = data_byte;
              pre_r.last  = (bl_r == 16'd1);
              bl_nxt      = bl_r - 16'd1;
              if (bl_nxt == 16'd0) begin
                ph_nxt = sfce_pkg::PH_IDLE;
                act    = ACT_FIN;
              end else begin
                act         = ACT_EMIT;
                emit_r.kind = sfce_pkg::OK_SPI;
                emit_r.tx   = sfce_pkg::FC_DUMMY;
                emit_r.fe   = (bl_nxt == 16'd1);
              end
            end
            sfce_pkg::PH_PDATA: begin
              pl_nxt   = pl_r - PW'(1);
              addr_nxt = addr_r + 32'd1;
              if (pl_nxt != '0) begin
                ph_nxt      = sfce_pkg::PH_PWANT;
                act         = ACT_EMIT;
                emit_r.kind = sfce_pkg::OK_WANT;
              end else begin
                tag_nxt = sfce_pkg::WT_CMD;
                pc_nxt  = '0;
                ph_nxt  = sfce_pkg::PH_POLL_OP;
                act     = ACT_POLL;
              end
            end
            sfce_pkg::PH_POLL_OP: begin
              ph_nxt      = sfce_pkg::PH_POLL_DATA;
              act         = ACT_EMIT;
              emit_r.kind = sfce_pkg::OK_SPI;
              emit_r.tx   = sfce_pkg::FC_DUMMY;
              emit_r.fe   = 1'b1;
            end
            sfce_pkg::PH_POLL_DATA: begin
              if (!data_byte[0]) begin
                ok = 1'b1;
              end else begin
                pc_nxt = pc_r + 16'd1;
                if (pc_nxt >= lim) begin
                  to_nxt = 1'b1;
                end else begin
                  ph_nxt      = sfce_pkg::PH_POLL_DLY;
                  act         = ACT_EMIT;
                  emit_r.kind = sfce_pkg::OK_DELAY;
                end
              end
              // wait over, good or timed out
              if (ok || pc_nxt >= lim) begin
                step_nxt = '0;
                act      = ACT_SEND;
                unique case (tag_r)
                  sfce_pkg::WT_EN4B: begin
                    if (ok) ph_nxt = sfce_pkg::PH_WREN;
                    else act = ACT_FIN;
                  end
                  sfce_pkg::WT_WREN: begin
                    case (op_r)
                      sfce_pkg::OP_EN4B: begin
                        if (ok) ph_nxt = sfce_pkg::PH_WRSR3;
                        else begin
                          tag_nxt = sfce_pkg::WT_CMD;
                          act     = ACT_POLL;
                        end
                      end
                      sfce_pkg::OP_SECTOR, sfce_pkg::OP_BLOCK:
                        ph_nxt = ok ? sfce_pkg::PH_ERASE : sfce_pkg::PH_WRDI;
                      sfce_pkg::OP_CHIP:
                        ph_nxt = ok ? sfce_pkg::PH_CHIP : sfce_pkg::PH_WRDI;
                      sfce_pkg::OP_PROG: begin
                        if (ok) begin
                          // open the next page, cut at the page boundary
                          if (bl_r > 16'(n)) begin
                            bl_nxt = bl_r - 16'(n);
                            pl_nxt = n;
                          end else begin
                            pl_nxt = PW'(bl_r);
                            bl_nxt = '0;
                          end
                          ph_nxt = sfce_pkg::PH_PHDR;
                        end else begin
                          ph_nxt = sfce_pkg::PH_WREN;
                        end
                      end
                      default: act = ACT_FIN;
                    endcase
                  end
                  default: begin
                    if (op_r == sfce_pkg::OP_EN4B) act = ACT_FIN;
                    else if (op_r == sfce_pkg::OP_PROG && bl_r != 16'd0)
                      ph_nxt = sfce_pkg::PH_WREN;
                    else if (op_r >= sfce_pkg::OP_SECTOR) ph_nxt = sfce_pkg::PH_WRDI;
                    else act = ACT_FIN;
                  end
                endcase
                if (act == ACT_FIN) ph_nxt = sfce_pkg::PH_IDLE;
                if (act == ACT_POLL) begin
                  pc_nxt = '0;
                  ph_nxt = sfce_pkg::PH_POLL_OP;
                end
              end
            end
            default: begin
              // frame byte answered: capture, then next byte or end of frame
              if ((ph_r == sfce_pkg::PH_STAT && step_r[0]) ||
                  (ph_r == sfce_pkg::PH_ID && step_r != 3'd0))
                rs_nxt = {rs_r[15:0], data_byte};
              if (ph_r == sfce_pkg::PH_SR3 && step_r == 3'd1) sr3_nxt = data_byte;
              step_nxt = st1;
              if (st1 < frame_len(ph_r, a4_r)) begin
                act = ACT_SEND;
              end else begin
                step_nxt = '0;
                case (ph_r)
                  sfce_pkg::PH_SR3: begin
                    if (sr3_nxt[0]) act = ACT_FIN;
                    else begin
                      ph_nxt = sfce_pkg::PH_EN4B;
                      act    = ACT_SEND;
                    end
                  end
                  sfce_pkg::PH_EN4B: begin
                    tag_nxt = sfce_pkg::WT_EN4B;
                    act     = ACT_POLL;
                  end
                  sfce_pkg::PH_WREN: begin
                    tag_nxt = sfce_pkg::WT_WREN;
                    act     = ACT_POLL;
                  end
                  sfce_pkg::PH_WRSR3, sfce_pkg::PH_ERASE, sfce_pkg::PH_CHIP: begin
                    tag_nxt = sfce_pkg::WT_CMD;
                    act     = ACT_POLL;
                  end
                  sfce_pkg::PH_RHDR: begin
                    if (bl_r == 16'd0) act = ACT_FIN;
                    else begin
                      ph_nxt      = sfce_pkg::PH_RDATA;
                      act         = ACT_EMIT;
                      emit_r.kind = sfce_pkg::OK_SPI;
                      emit_r.tx   = sfce_pkg::FC_DUMMY;
                      emit_r.fe   = (bl_r == 16'd1);
                    end
                  end
                  sfce_pkg::PH_PHDR: begin
                    if (pl_r == '0) begin
                      tag_nxt = sfce_pkg::WT_CMD;
                      act     = ACT_POLL;
                    end else begin
                      ph_nxt      = sfce_pkg::PH_PWANT;
                      act         = ACT_EMIT;
                      emit_r.kind = sfce_pkg::OK_WANT;
                    end
                  end
                  default: act = ACT_FIN;
                endcase
                if (act == ACT_FIN) ph_nxt = sfce_pkg::PH_IDLE;
                if (act == ACT_POLL) begin
                  pc_nxt = '0;
                  ph_nxt = sfce_pkg::PH_POLL_OP;
                end
              end
            end
          endcase
        end
      endcase
    end
  end

  // results written to the queue
  always_comb begin
    sfce_pkg::res_t ra;
    ra = '0;
    case (act)
      ACT_SEND: ra = send_now(ph_nxt, step_nxt, a4_nxt, addr_nxt, bl_nxt != 16'd0,
                              pl_nxt != '0, sr3_nxt, op_nxt);
      ACT_FIN: begin
        ra.kind = sfce_pkg::OK_DONE;
        ra.st   = to_nxt;
        if (op_nxt <= sfce_pkg::OP_ID) ra.rv = rs_nxt;
        else if (op_nxt == sfce_pkg::OP_EN4B) ra.rv = {16'd0, sr3_nxt};
      end
      ACT_POLL: begin
        ra.kind = sfce_pkg::OK_SPI;
        ra.tx   = sfce_pkg::FC_RDSR1;
      end
      ACT_EMIT: ra = emit_r;
      default:  ra = '0;
    endcase
    if (pre_v) begin
      wr.n  = 2'd2;
      wr.r0 = pre_r;
      wr.r1 = ra;
    end else begin
      wr.n  = (act != ACT_NONE) ? 2'd1 : 2'd0;
      wr.r0 = ra;
      wr.r1 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= sfce_pkg::PH_IDLE;
      tag_r  <= sfce_pkg::WT_EN4B;
      op_r   <= '0;
      addr_r <= '0;
      bl_r   <= '0;
      pl_r   <= '0;
      pc_r   <= '0;
      rs_r   <= '0;
      sr3_r  <= '0;
      step_r <= '0;
      a4_r   <= 1'b0;
      to_r   <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      tag_r  <= tag_nxt;
      op_r   <= op_nxt;
      addr_r <= addr_nxt;
      bl_r   <= bl_nxt;
      pl_r   <= pl_nxt;
      pc_r   <= pc_nxt;
      rs_r   <= rs_nxt;
      sr3_r  <= sr3_nxt;
      step_r <= step_nxt;
      a4_r   <= a4_nxt;
      to_r   <= to_nxt;
    end
  end

  assign idle = (ph_r == sfce_pkg::PH_IDLE);

  a_step_max: assert property (@(posedge clk) disable iff (!rst_n)
    step_r < 3'd6)
    else $error("frame byte step out of range");
  a_poll_lim: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r == sfce_pkg::PH_POLL_DLY |-> pc_r != 16'd0)
    else $error("poll delay without a busy reading");
  a_cmd_start: assert property (@(posedge clk) disable iff (!rst_n)
    go && kind == sfce_pkg::IK_CMD && idle |=> !idle)
    else $error("command did not start");

endmodule

// File: rtl/sfce_fifo.sv
// result queue, up to two writes and one read per cycle
module sfce_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  sfce_pkg::wr_t  wr,
  output logic           room,
  output logic           valid,
  input  logic           pop,
  output sfce_pkg::res_t head
);

  localparam int unsigned AW = $clog2(sfce_pkg::FIFO_DEPTH);

  sfce_pkg::res_t mem_r [sfce_pkg::FIFO_DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_pop;

  assign do_pop = pop & valid;

  always_comb begin
    wp_nxt  = wp_r + AW'(wr.n);
    rp_nxt  = rp_r + AW'(do_pop);
    cnt_nxt = cnt_r + (AW + 1)'(wr.n) - (AW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.n != 2'd0) mem_r[wp_r] <= wr.r0;
    if (wr.n == 2'd2) mem_r[AW'(wp_r + AW'(1))] <= wr.r1;
  end

  assign valid = (cnt_r != '0);
  assign room  = (cnt_r <= (AW + 1)'(sfce_pkg::FIFO_DEPTH - 2));
  assign head  = mem_r[rp_r];

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW + 1)'(sfce_pkg::FIFO_DEPTH))
    else $error("result queue overflow");
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr.n != 2'd0 |-> room)
    else $error("write without room");

endmodule
